// ----- rtl/lst_pkg.sv -----
// Shared types and codes for the LRU slot table.
// Used by lst_cell, lst_ctrl and lru_slot_table; depends on nothing.
package lst_pkg;

  // Widest field the records carry; modules cut down to their own widths.
  localparam int MAX_KEY_BITS   = 64;
  localparam int MAX_STAMP_BITS = 64;
  localparam int MAX_IDX_BITS   = 8;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_TOUCH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  // Search record that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                      valid;
    logic                      hit_found;
    logic [MAX_IDX_BITS-1:0]   hit_idx;
    logic                      free_found;
    logic [MAX_IDX_BITS-1:0]   free_idx;
    logic                      tgt_valid;
    logic                      min_found;
    logic [MAX_IDX_BITS-1:0]   min_idx;
    logic [MAX_STAMP_BITS-1:0] min_stamp;
    logic [MAX_KEY_BITS-1:0]   min_key;
  } probe_t;

  // Write broadcast from the controller to every cell.
  typedef struct packed {
    logic                      wr;
    logic [MAX_IDX_BITS-1:0]   idx;
    logic                      set_valid;
    logic                      valid_val;
    logic                      set_key;
    logic [MAX_KEY_BITS-1:0]   key;
    logic                      set_stamp;
    logic [MAX_STAMP_BITS-1:0] stamp;
  } upd_t;

endpackage

// ----- rtl/lst_cell.sv -----
// One slot of the table: valid bit, key and use stamp, plus one stage of
// the search record chain. Depends on lst_pkg.
module lst_cell #(
  parameter int CELL_IDX   = 0,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32,
  parameter int IDX_BITS   = 4,
  parameter int CNT_BITS   = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_BITS-1:0]   lim,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [IDX_BITS-1:0]   req_idx,
  input  lst_pkg::probe_t       probe_in,
  output lst_pkg::probe_t       probe_out,
  input  lst_pkg::upd_t         upd
);

  logic                  valid;
  logic [KEY_BITS-1:0]   key;
  logic [STAMP_BITS-1:0] stamp;

  lst_pkg::probe_t probe_next;
  logic            active;
  logic            sel;

  assign active = CNT_BITS'(CELL_IDX) < lim;
  assign sel    = upd.wr && (upd.idx == lst_pkg::MAX_IDX_BITS'(CELL_IDX));

  always_comb begin
    probe_next = probe_in;
    if (active) begin
      if (valid && (key == req_key) && !probe_in.hit_found) begin
        probe_next.hit_found = 1'b1;
        probe_next.hit_idx   = lst_pkg::MAX_IDX_BITS'(CELL_IDX);
      end
      if (!valid && !probe_in.free_found) begin
        probe_next.free_found = 1'b1;
        probe_next.free_idx   = lst_pkg::MAX_IDX_BITS'(CELL_IDX);
      end
      // strict less-than: lower index keeps ties
      if (valid && (!probe_in.min_found ||
                    (stamp < probe_in.min_stamp[STAMP_BITS-1:0]))) begin
        probe_next.min_found = 1'b1;
        probe_next.min_idx   = lst_pkg::MAX_IDX_BITS'(CELL_IDX);
        probe_next.min_stamp = lst_pkg::MAX_STAMP_BITS'(stamp);
        probe_next.min_key   = lst_pkg::MAX_KEY_BITS'(key);
      end
      if (req_idx == IDX_BITS'(CELL_IDX)) begin
        probe_next.tgt_valid = valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
      valid     <= 1'b0;
    end else begin
      probe_out <= probe_next;
      if (sel && upd.set_valid) begin
        valid <= upd.valid_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && upd.set_key) begin
      key <= upd.key[KEY_BITS-1:0];
    end
    if (sel && upd.set_stamp) begin
      stamp <= upd.stamp[STAMP_BITS-1:0];
    end
  end

endmodule

// ----- rtl/lst_ctrl.sv -----
// Request sequencer for the LRU slot table: launches the search down the
// cell row, decides the operation, writes back and holds the result.
// Depends on lst_pkg.
module lst_ctrl #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32,
  parameter int IDX_BITS   = 4,
  parameter int CNT_BITS   = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [IDX_BITS-1:0] in_idx,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [IDX_BITS-1:0] out_slot,
  output logic                out_evict,
  output logic [KEY_BITS-1:0] out_victim,
  output logic [CNT_BITS-1:0] out_occ,
  output logic [CNT_BITS-1:0] lim,
  output logic [KEY_BITS-1:0] req_key,
  output logic [IDX_BITS-1:0] req_idx,
  output lst_pkg::probe_t     launch,
  input  lst_pkg::probe_t     tail,
  output lst_pkg::upd_t       upd
);

  lst_pkg::state_t       state, state_next;
  lst_pkg::op_t          req_op;
  lst_pkg::probe_t       scan_rec;
  logic [CNT_BITS-1:0]   active_slots;
  logic [STAMP_BITS-1:0] use_clock, use_clock_next;
  logic [CNT_BITS-1:0]   valid_count, valid_count_next;

  logic [STAMP_BITS-1:0] new_stamp;
  logic                  commit;
  lst_pkg::status_t      res_status;
  logic [IDX_BITS-1:0]   res_slot;
  logic                  res_evict;
  logic [KEY_BITS-1:0]   res_victim;

  assign in_ready  = (state == lst_pkg::S_IDLE);
  assign commit    = (state == lst_pkg::S_DECIDE) && (!out_valid || out_ready);
  assign new_stamp = (use_clock == '1) ? use_clock : use_clock + STAMP_BITS'(1);
  assign lim       = ((active_slots == '0) || (active_slots > CNT_BITS'(SLOTS))) ?
                     CNT_BITS'(SLOTS) : active_slots;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lst_pkg::S_IDLE:   if (in_valid) state_next = lst_pkg::S_SCAN;
      lst_pkg::S_SCAN:   if (tail.valid) state_next = lst_pkg::S_DECIDE;
      lst_pkg::S_DECIDE: if (commit) state_next = lst_pkg::S_IDLE;
      default:           state_next = lst_pkg::S_IDLE;
    endcase
  end

  // decision and write-back
  always_comb begin
    upd              = '0;
    res_status       = lst_pkg::ST_MISS;
    res_slot         = '0;
    res_evict        = 1'b0;
    res_victim       = '0;
    use_clock_next   = use_clock;
    valid_count_next = valid_count;
    if (state == lst_pkg::S_DECIDE) begin
      unique case (req_op)
        lst_pkg::OP_FIND: begin
          if (scan_rec.hit_found) begin
            res_status = lst_pkg::ST_OK;
            res_slot   = scan_rec.hit_idx[IDX_BITS-1:0];
          end
        end
        lst_pkg::OP_ALLOC: begin
          if (scan_rec.hit_found) begin
            res_status = lst_pkg::ST_DUP;
            res_slot   = scan_rec.hit_idx[IDX_BITS-1:0];
          end else begin
            res_status     = lst_pkg::ST_OK;
            upd.wr         = commit;
            upd.set_valid  = 1'b1;
            upd.valid_val  = 1'b1;
            upd.set_key    = 1'b1;
            upd.key        = lst_pkg::MAX_KEY_BITS'(req_key);
            upd.set_stamp  = 1'b1;
            upd.stamp      = lst_pkg::MAX_STAMP_BITS'(new_stamp);
            use_clock_next = new_stamp;
            if (scan_rec.free_found) begin
              upd.idx          = scan_rec.free_idx;
              res_slot         = scan_rec.free_idx[IDX_BITS-1:0];
              valid_count_next = valid_count + CNT_BITS'(1);
            end else begin
              // every active slot holds an entry: replace the oldest
              upd.idx    = scan_rec.min_idx;
              res_slot   = scan_rec.min_idx[IDX_BITS-1:0];
              res_evict  = 1'b1;
              res_victim = scan_rec.min_key[KEY_BITS-1:0];
            end
          end
        end
        lst_pkg::OP_REMOVE: begin
          if (scan_rec.hit_found) begin
            res_status    = lst_pkg::ST_OK;
            res_slot      = scan_rec.hit_idx[IDX_BITS-1:0];
            upd.wr        = commit;
            upd.idx       = scan_rec.hit_idx;
            upd.set_valid = 1'b1;
            upd.valid_val = 1'b0;
            if (valid_count != '0) begin
              valid_count_next = valid_count - CNT_BITS'(1);
            end
          end
        end
        lst_pkg::OP_TOUCH: begin
          // tgt_valid is only set by an active cell
          if (scan_rec.tgt_valid) begin
            res_status     = lst_pkg::ST_OK;
            res_slot       = req_idx;
            upd.wr         = commit;
            upd.idx        = lst_pkg::MAX_IDX_BITS'(req_idx);
            upd.set_stamp  = 1'b1;
            upd.stamp      = lst_pkg::MAX_STAMP_BITS'(new_stamp);
            use_clock_next = new_stamp;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lst_pkg::S_IDLE;
      active_slots <= CNT_BITS'(SLOTS);
      use_clock    <= '0;
      valid_count  <= '0;
      launch       <= '0;
      scan_rec     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      // only the valid bit of the launched record ever moves
      launch.valid <= in_valid && in_ready;
      if (cfg_we) begin
        active_slots <= cfg_wdata;
      end
      if ((state == lst_pkg::S_SCAN) && tail.valid) begin
        scan_rec <= tail;
      end
      if (commit) begin
        use_clock   <= use_clock_next;
        valid_count <= valid_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op  <= lst_pkg::op_t'(in_op);
      req_key <= in_key;
      req_idx <= in_idx;
    end
    if (commit) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_evict  <= res_evict;
      out_victim <= res_victim;
      out_occ    <= valid_count_next;
    end
  end

`ifndef SYNTHESIS
  a_scan_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##(SLOTS+1) tail.valid)
    else $error("search record did not reach the end of the row on time");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == lst_pkg::S_SCAN))
    else $error("search record arrived outside a scan");

  a_write_on_commit: assert property (@(posedge clk) disable iff (rst)
    upd.wr |-> ((state == lst_pkg::S_DECIDE) && (!out_valid || out_ready)))
    else $error("slot write without a free result register");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CNT_BITS'(SLOTS))
    else $error("occupancy exceeds slot count");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(use_clock) <= use_clock)
    else $error("use clock went backward");
`endif

endmodule

// ----- rtl/lru_slot_table.sv -----
// Top level of the LRU slot table: a row of slot cells searched by a
// travelling record, driven by one sequencer. Depends on lst_pkg,
// lst_cell and lst_ctrl.
//
// Fully associative table of SLOTS entries, each a valid bit, a KEY_BITS
// key and a STAMP_BITS use stamp. A request is find, allocate, remove or
// touch (restamp by index); each request gives one response carrying a
// status (ok, not found, duplicate), the slot, an eviction flag with the
// evicted key, and the occupancy after the request. Allocate takes the
// lowest free active slot, else evicts the active slot with the smallest
// stamp, lowest index on ties. Stamps come from a use clock that counts
// up and sticks at its maximum. cfg_wdata sets how many slots, from slot
// 0, take part (0 or more than SLOTS means all); write it only while no
// request is in flight. Slots beyond the limit keep their contents and
// still count in the occupancy.
// Timing: one request at a time. Each request is launched, then the search
// record steps through one cell per cycle, then it is captured and decided.
// The response sits in an output register, so a new request is taken
// while the last response waits; a second one stalls in the decide state
// until the first is taken. No clearing pass is needed after reset.
module lru_slot_table #(
  parameter int SLOTS      = 16,
  parameter int KEY_BITS   = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [$clog2(SLOTS+1)-1:0]          cfg_wdata,    // active_slots
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation[1:0], key, slot_index, zero pad
  input  logic [((2+KEY_BITS+((SLOTS>1)?$clog2(SLOTS):1)+7)/8)*8-1:0]
                                              s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status[1:0], result_slot, did_evict, victim_key, occupancy, zero pad
  output logic [((3+((SLOTS>1)?$clog2(SLOTS):1)+KEY_BITS+$clog2(SLOTS+1)+7)/8)*8-1:0]
                                              m_axis_tdata
);

  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS = $clog2(SLOTS+1);
  localparam int OUT_W    = 3 + IDX_BITS + KEY_BITS + CNT_BITS;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

  // request fields
  logic [1:0]          in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [IDX_BITS-1:0] in_idx;

  assign in_op  = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[KEY_BITS+1:2];
  assign in_idx = s_axis_tdata[KEY_BITS+IDX_BITS+1:KEY_BITS+2];

  // response fields
  logic [1:0]          out_status;
  logic [IDX_BITS-1:0] out_slot;
  logic                out_evict;
  logic [KEY_BITS-1:0] out_victim;
  logic [CNT_BITS-1:0] out_occ;

  assign m_axis_tdata = OUT_TW'({out_occ, out_victim, out_evict, out_slot, out_status});

  // broadcast to the cells
  logic [CNT_BITS-1:0] lim;
  logic [KEY_BITS-1:0] req_key;
  logic [IDX_BITS-1:0] req_idx;
  lst_pkg::upd_t       upd;

  // chain[i] enters cell i; chain[SLOTS] returns to the sequencer
  lst_pkg::probe_t chain [SLOTS+1];

  lst_ctrl #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS),
    .IDX_BITS   (IDX_BITS),
    .CNT_BITS   (CNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (in_op),
    .in_key     (in_key),
    .in_idx     (in_idx),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_evict  (out_evict),
    .out_victim (out_victim),
    .out_occ    (out_occ),
    .lim        (lim),
    .req_key    (req_key),
    .req_idx    (req_idx),
    .launch     (chain[0]),
    .tail       (chain[SLOTS]),
    .upd        (upd)
  );

  // the row of slot cells; each hands the search record to the next
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lst_cell #(
      .CELL_IDX   (i),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .lim       (lim),
      .req_key   (req_key),
      .req_idx   (req_idx),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .upd       (upd)
    );
  end

endmodule

// ----- tb/tb_lru_slot_table.sv -----
// Self-checking testbench for lru_slot_table: a directed table, then random
// find/allocate/remove/touch traffic over several slot limits.
// Depends on lst_pkg and the lru_slot_table RTL.
module tb_lru_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 16;
  localparam int KEY_BITS   = 64;
  localparam int STAMP_BITS = 32;
  localparam int IDXW       = 4;
  localparam int CNTW       = 5;
  localparam int IN_W       = ((2 + KEY_BITS + IDXW + 7) / 8) * 8;
  localparam int OUT_W      = ((3 + IDXW + KEY_BITS + CNTW + 7) / 8) * 8;
  localparam int MAX_GAP    = 18;
  localparam int LONG_HOLD  = 300;   // receiver hold-off, long enough to back up the input
  localparam int SETTLE     = 25;    // a bit longer than a request takes from acceptance to the next acceptance
  localparam int POOL       = 20;    // a few more keys than slots, so the table churns
  localparam int PER_PHASE  = 100;
  localparam int MAX_PRINT  = 50;

  // One response as the checker sees it.
  typedef struct {
    lst_pkg::status_t    status;
    logic [IDXW-1:0]     slot;
    logic                evict;
    logic [KEY_BITS-1:0] victim;
    logic [CNTW-1:0]     occ;
  } reply_t;

  // One line of the directed table: a register write or a request, with an
  // optional hand-written response.
  typedef struct {
    logic                is_cfg;
    logic [CNTW-1:0]     cfg;
    lst_pkg::op_t        op;
    logic [KEY_BITS-1:0] key;
    logic [IDXW-1:0]     idx;
    logic                typed;
    reply_t              want;
  } step_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CNTW-1:0]     cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;   // operation[1:0], key[65:2], slot_index[69:66], pad
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;   // status[1:0], result_slot[5:2], did_evict[6],
                                       // victim_key[70:7], occupancy[75:71], pad

  always #5 clk = ~clk;

  lru_slot_table #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the table, kept in step with every accepted request.
  // ---------------------------------------------------------------------------
  logic                  slot_live [SLOTS] = '{default: 1'b0};
  logic [KEY_BITS-1:0]   slot_tag  [SLOTS] = '{default: '0};
  logic [STAMP_BITS-1:0] slot_age  [SLOTS] = '{default: '0};
  logic [STAMP_BITS-1:0] use_tick   = '0;
  logic [CNTW-1:0]       live_count = '0;
  logic [CNTW-1:0]       scan_cfg   = CNTW'(SLOTS);   // active_slots after reset

  reply_t pending_replies [$];   // responses owed by the block, oldest first
  int     mismatches    = 0;
  int     replies_taken = 0;
  int     hold_asked    = 0;     // bumped by stimulus, served by the receiver
  int     hold_served   = 0;
  bit     src_gaps      = 1'b1;
  bit     snk_gaps      = 1'b1;

  // Applies one request to the shadow table and returns the response it owes.
  function automatic reply_t table_outcome(lst_pkg::op_t op, logic [KEY_BITS-1:0] k,
                                           logic [IDXW-1:0] idx);
    reply_t r;
    int     lim;
    int     hit;
    int     pick;
    // 0 or anything past SLOTS means the whole table
    lim = (scan_cfg == 0 || scan_cfg > SLOTS) ? SLOTS : int'(scan_cfg);
    r.status = lst_pkg::ST_MISS;
    r.slot   = '0;
    r.evict  = 1'b0;
    r.victim = '0;
    hit = -1;
    for (int i = 0; i < lim; i++)
      if (hit < 0 && slot_live[i] && slot_tag[i] == k) hit = i;
    case (op)
      lst_pkg::OP_FIND: begin
        if (hit >= 0) begin
          r.status = lst_pkg::ST_OK;
          r.slot   = IDXW'(hit);
        end
      end
      lst_pkg::OP_ALLOC: begin
        if (hit >= 0) begin
          r.status = lst_pkg::ST_DUP;
          r.slot   = IDXW'(hit);
        end else begin
          pick = -1;
          for (int i = 0; i < lim; i++)
            if (pick < 0 && !slot_live[i]) pick = i;
          if (pick < 0) begin
            // table full within the limit: oldest stamp goes, lowest index on ties
            pick = 0;
            for (int i = 1; i < lim; i++)
              if (slot_age[i] < slot_age[pick]) pick = i;
            r.evict  = 1'b1;
            r.victim = slot_tag[pick];
          end else begin
            live_count++;
          end
          if (use_tick != '1) use_tick++;
          slot_live[pick] = 1'b1;
          slot_tag[pick]  = k;
          slot_age[pick]  = use_tick;
          r.status = lst_pkg::ST_OK;
          r.slot   = IDXW'(pick);
        end
      end
      lst_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          slot_tag[hit]  = '0;
          slot_age[hit]  = '0;
          if (live_count > 0) live_count--;
          r.status = lst_pkg::ST_OK;
          r.slot   = IDXW'(hit);
        end
      end
      lst_pkg::OP_TOUCH: begin
        // out-of-limit or empty slot is a plain miss
        if (int'(idx) < lim && slot_live[idx]) begin
          if (use_tick != '1) use_tick++;
          slot_age[idx] = use_tick;
          r.status = lst_pkg::ST_OK;
          r.slot   = idx;
        end
      end
      default: ;
    endcase
    r.occ = live_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    if (mismatches < MAX_PRINT) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_reply(logic [OUT_W-1:0] d);
    reply_t want;
    if (pending_replies.size() == 0) begin
      flag_mismatch($sformatf("response with no request waiting: %h", d));
    end else begin
      want = pending_replies.pop_front();
      if (d[1:0] !== 2'(want.status))
        flag_mismatch($sformatf("status %0d, want %0d", d[1:0], want.status));
      if (d[2 +: IDXW] !== want.slot)
        flag_mismatch($sformatf("result_slot %0d, want %0d", d[2 +: IDXW], want.slot));
      if (d[2 + IDXW] !== want.evict)
        flag_mismatch($sformatf("did_evict %b, want %b", d[2 + IDXW], want.evict));
      if (d[3 + IDXW +: KEY_BITS] !== want.victim)
        flag_mismatch($sformatf("victim_key %h, want %h",
                                d[3 + IDXW +: KEY_BITS], want.victim));
      if (d[3 + IDXW + KEY_BITS +: CNTW] !== want.occ)
        flag_mismatch($sformatf("occupancy %0d, want %0d",
                                d[3 + IDXW + KEY_BITS +: CNTW], want.occ));
    end
  endtask

  // Responses are taken at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_reply(m_axis_tdata);
      replies_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a fresh random wait before each response, plus the occasional
  // long hold-off so the output register and the decide stage both fill and
  // s_axis_tready drops while requests keep coming.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int stall;
    int seen;
    stall = 0;
    seen  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (seen != replies_taken) begin
        seen  = replies_taken;
        stall = snk_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        stall = LONG_HOLD;
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Called and returning at a falling edge. tvalid is only lowered
  // when a gap is drawn, so back-to-back requests keep it high without a glitch.
  // ---------------------------------------------------------------------------
  task automatic send_req(lst_pkg::op_t op, logic [KEY_BITS-1:0] k,
                          logic [IDXW-1:0] idx, logic typed, reply_t want);
    int              gap;
    logic [IN_W-1:0] word;
    reply_t          got;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[1:0]              = op;
    word[2 +: KEY_BITS]    = k;
    word[2 + KEY_BITS +: IDXW] = idx;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // accepted on this edge: shadow table moves now, in request order
    got = table_outcome(op, k, idx);
    pending_replies.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Register writes only with the block drained; every request answers, but
  // give it a request time anyway before touching the limit.
  task automatic set_active_slots(logic [CNTW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    scan_cfg   = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic step_t mk_req(lst_pkg::op_t op, logic [KEY_BITS-1:0] k,
                                   logic [IDXW-1:0] idx);
    step_t s;
    s.is_cfg = 1'b0;
    s.cfg    = '0;
    s.op     = op;
    s.key    = k;
    s.idx    = idx;
    s.typed  = 1'b0;
    s.want   = '{lst_pkg::ST_OK, '0, 1'b0, '0, '0};
    return s;
  endfunction

  function automatic step_t mk_chk(lst_pkg::op_t op, logic [KEY_BITS-1:0] k,
                                   logic [IDXW-1:0] idx, lst_pkg::status_t st, int slot,
                                   logic ev, logic [KEY_BITS-1:0] victim, int occ);
    step_t s;
    s = mk_req(op, k, idx);
    s.typed = 1'b1;
    s.want  = '{st, IDXW'(slot), ev, victim, CNTW'(occ)};
    return s;
  endfunction

  function automatic step_t mk_cfg(int v);
    step_t s;
    s = mk_req(lst_pkg::OP_FIND, '0, '0);
    s.is_cfg = 1'b1;
    s.cfg    = CNTW'(v);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  localparam logic [KEY_BITS-1:0] K_ZERO = '0;
  localparam logic [KEY_BITS-1:0] K_ONES = '1;
  localparam logic [KEY_BITS-1:0] K_FIVE = 64'h5555_5555_5555_5555;
  localparam logic [KEY_BITS-1:0] K_AAAA = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KEY_BITS-1:0] K_EDGE = 64'h8000_0000_0000_0001;
  localparam logic [KEY_BITS-1:0] K_MIX  = 64'h0123_4567_89AB_CDEF;

  initial begin : stim
    step_t               plan [$];
    logic [KEY_BITS-1:0] key_pool [POOL];
    int                  limits [10];
    int                  r;
    int                  guard;
    lst_pkg::op_t        op;
    logic [KEY_BITS-1:0] k;
    reply_t              none;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    none          = '{lst_pkg::ST_OK, '0, 1'b0, '0, '0};

    // Directed table. Stamps: alloc K_ZERO=1, alloc K_ONES=2, touch 0=3,
    // alloc K_FIVE=4, so the first eviction at limit 2 hits slot 1.
    // empty table
    plan.push_back(mk_chk(lst_pkg::OP_FIND,   K_ZERO, 0,  lst_pkg::ST_MISS, 0, 0, '0, 0));
    plan.push_back(mk_chk(lst_pkg::OP_REMOVE, K_ONES, 0,  lst_pkg::ST_MISS, 0, 0, '0, 0));
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ZERO, 0,  lst_pkg::ST_MISS, 0, 0, '0, 0));
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ONES, 15, lst_pkg::ST_MISS, 0, 0, '0, 0));
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_ZERO, 0,  lst_pkg::ST_OK,   0, 0, '0, 1));
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_ONES, 0,  lst_pkg::ST_OK,   1, 0, '0, 2));
    // duplicate key
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_ZERO, 0,  lst_pkg::ST_DUP,  0, 0, '0, 2));
    plan.push_back(mk_chk(lst_pkg::OP_FIND,   K_ONES, 0,  lst_pkg::ST_OK,   1, 0, '0, 2));
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ZERO, 0,  lst_pkg::ST_OK,   0, 0, '0, 2));
    // slot not valid
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ZERO, 15, lst_pkg::ST_MISS, 0, 0, '0, 2));
    plan.push_back(mk_chk(lst_pkg::OP_REMOVE, K_ZERO, 0,  lst_pkg::ST_OK,   0, 0, '0, 1));
    plan.push_back(mk_chk(lst_pkg::OP_FIND,   K_ZERO, 0,  lst_pkg::ST_MISS, 0, 0, '0, 1));
    // lowest free slot
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_FIVE, 0,  lst_pkg::ST_OK,   0, 0, '0, 2));
    plan.push_back(mk_cfg(2));
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_AAAA, 0,  lst_pkg::ST_OK,   1, 1, K_ONES, 2));
    // past the limit
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ZERO, 2,  lst_pkg::ST_MISS, 0, 0, '0, 2));
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_EDGE, 0,  lst_pkg::ST_OK,   0, 1, K_FIVE, 2));
    plan.push_back(mk_cfg(1));
    plan.push_back(mk_chk(lst_pkg::OP_ALLOC,  K_FIVE, 0,  lst_pkg::ST_OK,   0, 1, K_EDGE, 2));
    // slot 1 is hidden by the limit but still counted
    plan.push_back(mk_chk(lst_pkg::OP_FIND,   K_AAAA, 0,  lst_pkg::ST_MISS, 0, 0, '0, 2));
    plan.push_back(mk_chk(lst_pkg::OP_TOUCH,  K_ZERO, 1,  lst_pkg::ST_MISS, 0, 0, '0, 2));
    plan.push_back(mk_cfg(0));                                            // zero means all
    plan.push_back(mk_req(lst_pkg::OP_FIND,   K_AAAA, 0));
    plan.push_back(mk_req(lst_pkg::OP_ALLOC,  K_MIX,  0));
    plan.push_back(mk_cfg(31));                                           // clamped to all
    plan.push_back(mk_req(lst_pkg::OP_REMOVE, K_AAAA, 0));
    plan.push_back(mk_req(lst_pkg::OP_TOUCH,  K_ZERO, 2));
    plan.push_back(mk_req(lst_pkg::OP_ALLOC,  K_ONES, 0));

    key_pool[0] = K_ZERO;
    key_pool[1] = K_ONES;
    for (int i = 2; i < POOL; i++) key_pool[i] = {$urandom, $urandom};

    limits = '{16, 1, 4, 0, 31, 3, 16, 2, 17, 8};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_active_slots(plan[i].cfg);
      else send_req(plan[i].op, plan[i].key, plan[i].idx, plan[i].typed, plan[i].want);
    end

    // Random part: mostly pool keys so finds, removes and duplicates hit and the
    // table fills to eviction; a share of fresh 64-bit keys for the odd miss.
    foreach (limits[ph]) begin
      set_active_slots(CNTW'(limits[ph]));
      src_gaps = ($urandom_range(0, 3) != 0);
      snk_gaps = ($urandom_range(0, 3) != 0);
      if (ph == 1 || ph == 6) hold_asked++;
      repeat (PER_PHASE) begin
        r  = $urandom_range(0, 99);
        op = (r < 40) ? lst_pkg::OP_ALLOC :
             (r < 60) ? lst_pkg::OP_FIND :
             (r < 75) ? lst_pkg::OP_REMOVE : lst_pkg::OP_TOUCH;
        k  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL - 1)]
                                        : {$urandom, $urandom};
        send_req(op, k, IDXW'($urandom_range(0, SLOTS - 1)), 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_replies.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE * 2) @(posedge clk);
    if (pending_replies.size() != 0)
      flag_mismatch($sformatf("%0d requests never answered", pending_replies.size()));

    if (mismatches == 0) begin
      $display("** lru_slot_table: PASSED **");
    end else begin
      $display("** lru_slot_table: FAILED **");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("** lru_slot_table: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lst_pkg.sv
rtl/lst_cell.sv
rtl/lst_ctrl.sv
rtl/lru_slot_table.sv
tb/tb_lru_slot_table.sv
